>>> hw/rtl/uartrx_pkg.sv
// Shared types, constants and helpers for the UART receiver core.
// No dependencies; imported by every module under hw/rtl.
package uartrx_pkg;

   localparam int unsigned CNT_W       = 12;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned BITS_W      = 4;
   localparam int unsigned TRAIL_W     = 2;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned FIFO_DEPTH  = 3;
   localparam int unsigned FIFO_PTR_W  = 2;
   localparam int unsigned FIFO_CNT_W  = 2;

   localparam logic [BITS_W-1:0]  DATA_BITS        = 4'd8;
   localparam logic [CNT_W-1:0]   RST_FIRST_DELAY  = 12'd156;
   localparam logic [CNT_W-1:0]   RST_BIT_PERIOD   = 12'd104;
   localparam logic [TRAIL_W-1:0] RST_TRAIL_BITS   = 2'd1;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BIT_PERIOD  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRAIL_BITS  = 2'd2;

   typedef enum logic [1:0] {
      PHASE_IDLE  = 2'd0,
      PHASE_DATA  = 2'd1,
      PHASE_TRAIL = 2'd2
   } phase_type;

   typedef struct packed {
      logic [CNT_W-1:0]   first_delay;
      logic [CNT_W-1:0]   bit_period;
      logic [TRAIL_W-1:0] trail_bits;
   } cfg_type;

   // A zero count behaves as one tick.
   function automatic logic [CNT_W-1:0] at_least_one(input logic [CNT_W-1:0] v);
      at_least_one = (v == '0) ? CNT_W'(1) : v;
   endfunction

endpackage

>>> hw/rtl/uartrx_frame.sv
// Frame sequencer: start-edge detect, bit timing and byte assembly.
// Depends on uartrx_pkg. One registered tick is processed per cycle.
module uartrx_frame import uartrx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              tick_valid,
   input  logic              tick_level,
   output logic              byte_valid,
   output logic [BYTE_W-1:0] byte_data
);

   phase_type          phase_ff, phase_in;
   logic               prev_ff, prev_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [BITS_W-1:0]  bits_ff, bits_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;

   logic [CNT_W-1:0]   count_dec;
   logic [BITS_W-1:0]  bits_inc;
   logic [BYTE_W-1:0]  shift_next;

   assign count_dec  = count_ff - CNT_W'(1);
   assign bits_inc   = bits_ff + BITS_W'(1);
   assign shift_next = {tick_level, shift_ff[BYTE_W-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         prev_ff  <= 1'b1;
         count_ff <= '0;
         bits_ff  <= '0;
         shift_ff <= '0;
      end else if (tick_valid) begin
         phase_ff <= phase_in;
         prev_ff  <= prev_in;
         count_ff <= count_in;
         bits_ff  <= bits_in;
         shift_ff <= shift_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      prev_in    = tick_level;
      count_in   = count_ff;
      bits_in    = bits_ff;
      shift_in   = shift_ff;
      byte_valid = 1'b0;
      byte_data  = shift_next;
      unique case (phase_ff)
         PHASE_DATA: begin
            count_in = count_dec;
            if (count_dec == '0) begin
               shift_in = shift_next;
               bits_in  = bits_inc;
               if (bits_inc >= DATA_BITS) begin
                  byte_valid = tick_valid;
                  bits_in    = '0;
                  if (cfg.trail_bits == '0) begin
                     phase_in = PHASE_IDLE;
                  end else begin
                     phase_in = PHASE_TRAIL;
                     count_in = at_least_one(cfg.bit_period);
                  end
               end else begin
                  count_in = at_least_one(cfg.bit_period);
               end
            end
         end
         PHASE_TRAIL: begin
            count_in = count_dec;
            if (count_dec == '0) begin
               bits_in = bits_inc;
               if (bits_inc >= BITS_W'(cfg.trail_bits)) begin
                  phase_in = PHASE_IDLE;
                  bits_in  = '0;
               end else begin
                  count_in = at_least_one(cfg.bit_period);
               end
            end
         end
         default: begin
            // idle, and the unused code behaves as idle
            phase_in = PHASE_IDLE;
            if (prev_ff && !tick_level) begin
               phase_in = PHASE_DATA;
               count_in = at_least_one(cfg.first_delay);
               bits_in  = '0;
               shift_in = '0;
            end
         end
      endcase
   end

endmodule

>>> hw/rtl/uartrx_out_fifo.sv
// Small result queue between the sequencer and the response channel.
// Depends on uartrx_pkg; register-based, FIFO_DEPTH entries.
module uartrx_out_fifo import uartrx_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [BYTE_W-1:0] push_data,
   input  logic              pop,
   output logic              not_empty,
   output logic [BYTE_W-1:0] head_data,
   output logic [FIFO_CNT_W-1:0] count
);

   logic [BYTE_W-1:0]     mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ff, wr_in;
   logic [FIFO_PTR_W-1:0] rd_ff, rd_in;
   logic [FIFO_CNT_W-1:0] cnt_ff, cnt_in;
   logic                  do_pop;

   function automatic logic [FIFO_PTR_W-1:0] ptr_next(input logic [FIFO_PTR_W-1:0] p);
      ptr_next = (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
   endfunction

   assign not_empty = (cnt_ff != '0);
   assign head_data = mem_ff[rd_ff];
   assign count     = cnt_ff;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_in  = push   ? ptr_next(wr_ff) : wr_ff;
      rd_in  = do_pop ? ptr_next(rd_ff) : rd_ff;
      cnt_in = cnt_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> hw/rtl/uart_receiver_parity_skip_core.sv
// UART receiver core, 8 data bits, trailing bits skipped: top level.
// Depends on uartrx_pkg, uartrx_frame and uartrx_out_fifo.
//
// One request is one tick of the sampled receive line (tdata bit 0) and the
// core takes one request per clock cycle while req_tready is high. Each
// request is registered, then the frame sequencer handles it in the next
// cycle: a falling edge while idle starts a frame, data bit 0 is sampled
// first_sample_delay ticks after the edge tick and later bits bit_period
// ticks apart (a value of 0 acts as 1). The byte goes out on the tick of the
// eighth sample, LSB first received in bit 0; then trailing_bits further bits
// (0..3) are sampled and dropped. Stop and parity bits are never checked.
// rsp_tvalid rises once the sequencer has written the byte into the queue.
// Bytes wait in a three-entry queue, so req_tready stays high as long as
// rsp_tready is not held low across two or more whole bytes; it drops only
// when the queue plus the tick in flight could overflow.
// CSR writes (index 0 first_sample_delay, 1 bit_period, 2 trailing_bits;
// other indexes ignored) are always accepted; the two delays take effect at
// the next countdown load, trailing_bits at the next sample that tests it.
module uart_receiver_parity_skip_core import uartrx_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [0] line_level, [7:1] zero
   // response channel
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [BYTE_W-1:0]    rsp_tdata,   // [7:0] received_byte
   // register write channel
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CNT_W-1:0]     csr_data
);

   cfg_type cfg_ff, cfg_in;

   // input register
   logic in_valid_ff, in_valid_in;
   logic in_level_ff;

   logic                  byte_valid;
   logic [BYTE_W-1:0]     byte_data;
   logic [FIFO_CNT_W-1:0] fifo_count;
   logic                  req_fire;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_FIRST_DELAY: cfg_in.first_delay = csr_data;
            CSR_BIT_PERIOD:  cfg_in.bit_period  = csr_data;
            CSR_TRAIL_BITS:  cfg_in.trail_bits  = csr_data[TRAIL_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_delay <= RST_FIRST_DELAY;
         cfg_ff.bit_period  <= RST_BIT_PERIOD;
         cfg_ff.trail_bits  <= RST_TRAIL_BITS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Room check: queued bytes plus the tick in flight plus this one.
   assign req_tready  = ({1'b0, fifo_count} + {2'b00, in_valid_ff})
                        < 3'(FIFO_DEPTH);
   assign req_fire    = req_tvalid && req_tready;
   assign in_valid_in = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_level_ff <= req_tdata[0];
      end
   end

   uartrx_frame u_frame (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .tick_valid (in_valid_ff),
      .tick_level (in_level_ff),
      .byte_valid (byte_valid),
      .byte_data  (byte_data)
   );

   uartrx_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_valid),
      .push_data (byte_data),
      .pop       (rsp_tready),
      .not_empty (rsp_tvalid),
      .head_data (rsp_tdata),
      .count     (fifo_count)
   );

endmodule
